@@ rtl/core/htfd_pkg.sv @@
// Shared types, constants and the CRC-8 step function for the humidity/temperature
// frame decoder. No dependencies; every other file of the block imports it.

package htfd_pkg;

    // Reply byte layout and CRC-8 (poly 0x31, init 0xFF, MSB first, no final XOR)
    localparam logic [7:0] CRC_INIT = 8'hFF;
    localparam logic [7:0] CRC_POLY = 8'h31;

    // Byte positions inside a six-byte reply
    localparam logic [2:0] POS_W0_HI  = 3'd0;
    localparam logic [2:0] POS_W0_LO  = 3'd1;
    localparam logic [2:0] POS_CRC0   = 3'd2;
    localparam logic [2:0] POS_W1_HI  = 3'd3;
    localparam logic [2:0] POS_W1_LO  = 3'd4;
    localparam logic [2:0] POS_CRC1   = 3'd5;

    // Fixed-point conversion constants
    localparam int unsigned TEMP_SCALE  = 17500;  // centi-degrees C span
    localparam int unsigned TEMP_OFFSET = 4500;   // -45.00 C
    localparam int unsigned HUM_SCALE   = 10000;  // centi-percent span
    localparam int unsigned HUM_MAX     = 10000;
    localparam int unsigned FAHR_BIAS   = 40500;  // 8100 * 5, keeps 9*C + bias >= 0
    localparam int unsigned FAHR_RECIP  = 52429;  // ceil(2^18 / 5)
    localparam int unsigned FAHR_SHIFT  = 18;
    localparam int unsigned FAHR_OFFSET = 4900;   // 8100 - 3200

    // Default depth of the queue between front and back
    localparam int unsigned HTFD_QUEUE_DEPTH = 2;

    // APB address width: one 32-bit register at byte address 0
    localparam int unsigned APB_AW = 3;
    localparam int unsigned APB_DW = 32;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_CRC0 = 2'd1,
        ST_CRC1 = 2'd2
    } t_status;

    typedef enum logic {
        KIND_MEAS   = 1'b0,
        KIND_SERIAL = 1'b1
    } t_kind;

    localparam logic REG_FRAME_KIND = 1'b0;  // register index (paddr[2])

    // One checked frame, handed from front to back
    typedef struct packed {
        logic [15:0] w0;
        logic [15:0] w1;
        t_status     status;
        t_kind       kind;
    } t_frame;

    // Queue state seen by both sides
    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

    function automatic logic [7:0] crc8_step(input logic [7:0] crc_in, input logic [7:0] b);
        logic [7:0] c;
        c = crc_in ^ b;
        for (int k = 0; k < 8; k++) begin
            c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

endpackage

@@ rtl/core/htfd_if.sv @@
// Valid/ready channel interfaces for reply bytes in and decoded readings out.
// Depends on htfd_pkg.

interface htfd_byte_if import htfd_pkg::*; ();
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       frame_start;

    modport source (output valid, output data_byte, output frame_start, input ready);
    modport sink   (input valid, input data_byte, input frame_start, output ready);
endinterface

interface htfd_result_if import htfd_pkg::*; ();
    logic               valid;
    logic               ready;
    logic signed [14:0] temp_centi_c;
    logic signed [15:0] temp_centi_f;
    logic [13:0]        humidity_centi;
    logic [31:0]        serial_number;
    logic [1:0]         status;
    logic               reading_valid;

    modport source (output valid, output temp_centi_c, output temp_centi_f,
                    output humidity_centi, output serial_number, output status,
                    output reading_valid, input ready);
    modport sink   (input valid, input temp_centi_c, input temp_centi_f,
                    input humidity_centi, input serial_number, input status,
                    input reading_valid, output ready);
endinterface

@@ rtl/core/humidity_temp_frame_decoder_unit.sv @@
// Humidity/temperature reply frame decoder: six reply bytes in, one reading word out.
// Throughput: one byte per cycle while the queue is not full; the back end converts
// one frame while the front end collects the next. After the sixth byte is accepted the
// frame passes pop, multiply, divide, Fahrenheit multiply and output load, and the result
// word waits while the output stalls. Reset is synchronous, active low: clears the
// byte position, queue, held reading and frame_kind; no clearing pass is needed.

module humidity_temp_frame_decoder_unit import htfd_pkg::*; #(
    parameter int unsigned QUEUE_DEPTH = HTFD_QUEUE_DEPTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    htfd_byte_if.sink         i_byte,
    htfd_result_if.source     o_result,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    t_kind  r_frame_kind;
    logic   cfg_write;
    logic   push;
    t_frame push_frame;
    logic   pop;
    t_frame head;
    t_qstat qstat;

    // Configuration: one register, frame_kind, at byte address 0.
    // Writes complete in the access phase; pready is tied high.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_kind <= KIND_MEAS;
        end else if (cfg_write && paddr[2] == REG_FRAME_KIND) begin
            r_frame_kind <= t_kind'(pwdata[0]);
        end
    end

    // Read back frame_kind; anything beyond the register list reads as zero
    assign prdata = (paddr[2] == REG_FRAME_KIND) ? APB_DW'(r_frame_kind) : '0;

    // Front: position tracking and on-the-fly CRC; one frame pushed per sixth byte.
    // frame_kind is sampled as the frame closes.
    htfd_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_byte  (i_byte),
        .i_kind  (r_frame_kind),
        .i_qstat (qstat),
        .o_push  (push),
        .o_frame (push_frame)
    );

    // Queue: decouple byte intake from the multi-cycle conversion and output stalls
    htfd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_frame),
        .i_pop   (pop),
        .o_head  (head),
        .o_stat  (qstat)
    );

    // Back: conversion, held reading, output register
    htfd_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (head),
        .i_qstat (qstat),
        .o_pop   (pop),
        .o_res   (o_result)
    );

endmodule

@@ rtl/core/htfd_front.sv @@
// Front end: accepts reply bytes, tracks byte position, runs the CRC-8 on the fly
// and pushes one checked frame per six bytes. Depends on htfd_pkg, htfd_if.

module htfd_front import htfd_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    htfd_byte_if.sink     i_byte,
    input  t_kind         i_kind,
    input  t_qstat        i_qstat,
    output logic          o_push,
    output t_frame        o_frame
);

    logic [2:0]  r_pos, n_pos;
    logic [7:0]  r_crc, n_crc;
    logic        r_bad0, n_bad0;
    logic [15:0] r_w0, n_w0;
    logic [15:0] r_w1, n_w1;
    logic [2:0]  eff_pos;
    logic        accept;
    logic        bad1;
    t_status     frame_status;

    assign i_byte.ready = !i_qstat.full;
    assign accept       = i_byte.valid && i_byte.ready;
    assign eff_pos      = i_byte.frame_start ? POS_W0_HI : r_pos;
    assign bad1         = (r_crc != i_byte.data_byte);

    always_comb begin
        n_pos  = r_pos;
        n_crc  = r_crc;
        n_bad0 = r_bad0;
        n_w0   = r_w0;
        n_w1   = r_w1;
        if (accept) begin
            n_pos = (eff_pos == POS_CRC1) ? POS_W0_HI : eff_pos + 3'd1;
            unique case (eff_pos)
                POS_W0_HI: begin
                    n_w0[15:8] = i_byte.data_byte;
                    n_crc      = crc8_step(CRC_INIT, i_byte.data_byte);
                end
                POS_W0_LO: begin
                    n_w0[7:0] = i_byte.data_byte;
                    n_crc     = crc8_step(r_crc, i_byte.data_byte);
                end
                POS_CRC0: begin
                    n_bad0 = (r_crc != i_byte.data_byte);
                end
                POS_W1_HI: begin
                    n_w1[15:8] = i_byte.data_byte;
                    n_crc      = crc8_step(CRC_INIT, i_byte.data_byte);
                end
                POS_W1_LO: begin
                    n_w1[7:0] = i_byte.data_byte;
                    n_crc     = crc8_step(r_crc, i_byte.data_byte);
                end
                default: begin
                    n_pos = POS_W0_HI;  // sixth byte, or an out-of-range position
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= POS_W0_HI;
        end else begin
            r_pos <= n_pos;
        end
        r_crc  <= n_crc;
        r_bad0 <= n_bad0;
        r_w0   <= n_w0;
        r_w1   <= n_w1;
    end

    // Sixth byte closes the frame: first failing CRC wins
    always_comb begin
        priority if (r_bad0) begin
            frame_status = ST_CRC0;
        end else if (bad1) begin
            frame_status = ST_CRC1;
        end else begin
            frame_status = ST_OK;
        end
    end

    assign o_push         = accept && (eff_pos == POS_CRC1);
    assign o_frame.w0     = r_w0;
    assign o_frame.w1     = r_w1;
    assign o_frame.kind   = i_kind;
    assign o_frame.status = frame_status;

    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= POS_CRC1)
        else $error("byte position out of range");

endmodule

@@ rtl/core/htfd_queue.sv @@
// Short FIFO of checked frames between the front end and the conversion back end.
// Depends on htfd_pkg.

module htfd_queue import htfd_pkg::*; #(
    parameter int unsigned DEPTH = HTFD_QUEUE_DEPTH
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_frame i_data,
    input  logic   i_pop,
    output t_frame o_head,
    output t_qstat o_stat
);

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    t_frame        r_mem [DEPTH];
    logic [AW-1:0] r_wr_ptr, r_rd_ptr;
    logic [CW-1:0] r_count;
    logic          do_push, do_pop;

    function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
        return (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
    endfunction

    assign o_stat.full  = (r_count == CW'(DEPTH));
    assign o_stat.empty = (r_count == '0);
    assign do_push      = i_push && !o_stat.full;
    assign do_pop       = i_pop && !o_stat.empty;
    assign o_head       = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= ptr_inc(r_wr_ptr);
            end
            if (do_pop) begin
                r_rd_ptr <= ptr_inc(r_rd_ptr);
            end
            r_count <= r_count + CW'(do_push) - CW'(do_pop);
        end
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("queue count exceeds depth");

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stat.full && !do_pop |=> r_count == CW'(DEPTH))
        else $error("queue lost an entry while full");

endmodule

@@ rtl/core/htfd_back.sv @@
// Back end: converts a checked frame to fixed-point readings, keeps the last good
// reading and drives the output register. Depends on htfd_pkg, htfd_if.

module htfd_back import htfd_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  t_frame          i_head,
    input  t_qstat          i_qstat,
    output logic            o_pop,
    htfd_result_if.source   o_res
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_MUL  = 5'b00010,
        S_DIV  = 5'b00100,
        S_FMUL = 5'b01000,
        S_FOUT = 5'b10000
    } t_state;

    t_state              r_state, n_state;
    t_frame              r_frame;
    logic [30:0]         r_prod_t;
    logic [29:0]         r_prod_h;
    logic [33:0]         r_fprod;
    logic signed [14:0]  r_held_temp;
    logic [13:0]         r_held_hum;
    logic                r_have;
    logic                r_out_valid;
    logic signed [14:0]  r_out_tc;
    logic signed [15:0]  r_out_tf;
    logic [13:0]         r_out_rh;
    logic [31:0]         r_out_sn;
    logic [1:0]          r_out_st;
    logic                r_out_rv;

    logic [31:0]         sum_t, sum_h;
    logic [15:0]         q_t, q_h;
    logic [13:0]         hum_clamped;
    logic signed [18:0]  held_x, fahr_s;
    logic [14:0]         fahr_q;
    logic                good_meas;
    logic                load_out;

    assign o_pop    = (r_state == S_IDLE) && !i_qstat.empty;
    assign load_out = (r_state == S_FOUT) && (!r_out_valid || o_res.ready);

    // x / 65535 as (x + (x >> 16) + 1) >> 16, exact for x < 2^32 - 1
    assign sum_t       = 32'(r_prod_t) + 32'(r_prod_t >> 16) + 32'd1;
    assign sum_h       = 32'(r_prod_h) + 32'(r_prod_h >> 16) + 32'd1;
    assign q_t         = sum_t[31:16];
    assign q_h         = sum_h[31:16];
    assign hum_clamped = (q_h > 16'(HUM_MAX)) ? 14'(HUM_MAX) : q_h[13:0];
    assign good_meas   = (r_frame.kind == KIND_MEAS) && (r_frame.status == ST_OK);

    // 9*C + 40500 is never negative for C >= -4500
    assign held_x = 19'(r_held_temp);
    assign fahr_s = (held_x <<< 3) + held_x + 19'sd40500;
    assign fahr_q = r_fprod[FAHR_SHIFT +: 15];

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (!i_qstat.empty) n_state = S_MUL;
            S_MUL:  n_state = S_DIV;
            S_DIV:  n_state = S_FMUL;
            S_FMUL: n_state = S_FOUT;
            S_FOUT: if (load_out) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_have      <= 1'b0;
            r_held_temp <= '0;
            r_held_hum  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_DIV && good_meas) begin
                r_held_temp <= signed'(q_t[14:0] - 15'(TEMP_OFFSET));
                r_held_hum  <= hum_clamped;
                r_have      <= 1'b1;
            end
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (o_pop) begin
            r_frame <= i_head;
        end
        if (r_state == S_MUL) begin
            r_prod_t <= 31'(r_frame.w0) * 31'(TEMP_SCALE);
            r_prod_h <= 30'(r_frame.w1) * 30'(HUM_SCALE);
        end
        if (r_state == S_FMUL) begin
            r_fprod <= 34'(fahr_s[17:0]) * 34'(FAHR_RECIP);
        end
        if (load_out) begin
            r_out_tc <= r_have ? r_held_temp : '0;
            r_out_tf <= r_have ? signed'(16'(fahr_q) - 16'(FAHR_OFFSET)) : '0;
            r_out_rh <= r_have ? r_held_hum : '0;
            r_out_sn <= (r_frame.kind == KIND_SERIAL && r_frame.status == ST_OK) ?
                        {r_frame.w0, r_frame.w1} : '0;
            r_out_st <= r_frame.status;
            r_out_rv <= r_have;
        end
    end

    assign o_res.valid          = r_out_valid;
    assign o_res.temp_centi_c   = r_out_tc;
    assign o_res.temp_centi_f   = r_out_tf;
    assign o_res.humidity_centi = r_out_rh;
    assign o_res.serial_number  = r_out_sn;
    assign o_res.status         = r_out_st;
    assign o_res.reading_valid  = r_out_rv;

    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_out_rv |-> r_out_tc == '0 && r_out_tf == '0 && r_out_rh == '0)
        else $error("readings not zero without a good measurement");

    a_bad_no_serial: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_st != ST_OK |-> r_out_sn == '0)
        else $error("serial number shown for a failed frame");

    a_have_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_have |=> r_have)
        else $error("held reading lost");

endmodule
